// ===== hw/rtl/tkfr_pkg.sv =====
// Package for the token framed packet receiver.
// Holds the frame phase type, result kind codes, token constants, register reset values,
// operation codes, configuration indexes and the result struct. No dependencies.
`timescale 1ns / 1ps

package tkfr_pkg;

	// Framing tokens.
	localparam logic [7:0] START_TOKEN = 8'h01;
	localparam logic [7:0] END_TOKEN   = 8'hFE;

	// Register reset values.
	localparam logic [7:0]  NODE_ADDRESS_RST  = 8'd0;
	localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd25000;

	// Input operation codes.
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Configuration register indexes.
	localparam logic CFG_NODE_ADDRESS  = 1'b0;
	localparam logic CFG_TIMEOUT_TICKS = 1'b1;

	// Reception phase of the frame parser.
	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_LENGTH  = 3'd1,
		PH_ADDRESS = 3'd2,
		PH_COMMAND = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_CKSUM   = 3'd5,
		PH_ENDTOK  = 3'd6
	} phase_t;

	// Kind of a result item.
	typedef enum logic [2:0] {
		KIND_PAYLOAD  = 3'd0,
		KIND_ACCEPTED = 3'd1,
		KIND_BAD_SUM  = 3'd2,
		KIND_BAD_END  = 3'd3,
		KIND_TIMEOUT  = 3'd4
	} kind_t;

	// One result item as it travels from the parser to the output register.
	typedef struct packed {
		kind_t      kind;
		logic [7:0] payload_byte;
		logic [7:0] payload_index;
		logic [7:0] command;
		logic [7:0] length;
	} result_t;

endpackage

// ===== hw/rtl/tkfr_deframer.sv =====
// Frame parser of the token framed packet receiver: phase state machine,
// checksum, inactivity timer and result generation. Depends on tkfr_pkg.
`timescale 1ns / 1ps

module tkfr_deframer (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic                  op,
	input  logic [7:0]            rx_byte,
	input  logic [7:0]            node_address,
	input  logic [15:0]           timeout_ticks,
	output logic                  res_valid,
	output tkfr_pkg::result_t     res
);

	tkfr_pkg::phase_t phase_q, phase_d;
	logic [7:0]  frame_length_q, frame_length_d;
	logic [7:0]  running_sum_q, running_sum_d;
	logic [7:0]  byte_index_q, byte_index_d;
	logic [7:0]  command_byte_q, command_byte_d;
	logic        addressed_q, addressed_d;
	logic        checksum_ok_q, checksum_ok_d;
	logic [15:0] idle_count_q, idle_count_d;
	logic        timer_on_q, timer_on_d;

	logic [16:0] tick_next;
	logic        timed_out;
	logic [7:0]  index_next;

	assign tick_next  = {1'b0, idle_count_q} + 17'd1;
	assign timed_out  = tick_next >= {1'b0, timeout_ticks};
	assign index_next = byte_index_q + 8'd1;

	// Next state and result for the item in the input register.
	always_comb begin
		logic restart;
		tkfr_pkg::kind_t kind;
		restart         = 1'b0;
		kind            = tkfr_pkg::KIND_PAYLOAD;
		res_valid       = 1'b0;
		phase_d         = phase_q;
		frame_length_d  = frame_length_q;
		running_sum_d   = running_sum_q;
		byte_index_d    = byte_index_q;
		command_byte_d  = command_byte_q;
		addressed_d     = addressed_q;
		checksum_ok_d   = checksum_ok_q;
		idle_count_d    = idle_count_q;
		timer_on_d      = timer_on_q;
		res.payload_byte  = 8'd0;
		res.payload_index = 8'd0;

		if (op == tkfr_pkg::OP_TICK) begin
			if (timer_on_q) begin
				if (timed_out) begin
					restart = 1'b1;
					// Only an addressed frame that got past its address reports.
					if (addressed_q && (phase_q == tkfr_pkg::PH_COMMAND ||
						phase_q == tkfr_pkg::PH_PAYLOAD || phase_q == tkfr_pkg::PH_CKSUM ||
						phase_q == tkfr_pkg::PH_ENDTOK)) begin
						res_valid = 1'b1;
						kind      = tkfr_pkg::KIND_TIMEOUT;
					end
				end else begin
					idle_count_d = tick_next[15:0];
				end
			end
		end else begin
			idle_count_d = 16'd0;
			unique case (phase_q)
				tkfr_pkg::PH_IDLE: begin
					restart = 1'b1;
				end
				tkfr_pkg::PH_LENGTH: begin
					frame_length_d = rx_byte;
					running_sum_d  = running_sum_q + rx_byte;
					phase_d        = tkfr_pkg::PH_ADDRESS;
				end
				tkfr_pkg::PH_ADDRESS: begin
					if (rx_byte == node_address) begin
						running_sum_d = running_sum_q + rx_byte;
					end else begin
						addressed_d = 1'b0;
					end
					phase_d = tkfr_pkg::PH_COMMAND;
				end
				tkfr_pkg::PH_COMMAND: begin
					if (addressed_q) begin
						command_byte_d = rx_byte;
						running_sum_d  = running_sum_q + rx_byte;
					end
					phase_d = (frame_length_q != 8'd0) ? tkfr_pkg::PH_PAYLOAD
						: tkfr_pkg::PH_CKSUM;
				end
				tkfr_pkg::PH_PAYLOAD: begin
					byte_index_d = index_next;
					if (index_next >= frame_length_q) begin
						phase_d = tkfr_pkg::PH_CKSUM;
					end
					if (addressed_q) begin
						running_sum_d     = running_sum_q + rx_byte;
						res_valid         = 1'b1;
						kind              = tkfr_pkg::KIND_PAYLOAD;
						res.payload_byte  = rx_byte;
						res.payload_index = byte_index_q;
					end
				end
				tkfr_pkg::PH_CKSUM: begin
					if (rx_byte != ~running_sum_q) begin
						checksum_ok_d = 1'b0;
					end
					phase_d = tkfr_pkg::PH_ENDTOK;
				end
				tkfr_pkg::PH_ENDTOK: begin
					// A bad checksum outranks a bad end token.
					restart   = 1'b1;
					res_valid = addressed_q;
					if (!checksum_ok_q) begin
						kind = tkfr_pkg::KIND_BAD_SUM;
					end else if (rx_byte != tkfr_pkg::END_TOKEN) begin
						kind = tkfr_pkg::KIND_BAD_END;
					end else begin
						kind = tkfr_pkg::KIND_ACCEPTED;
					end
				end
				default: begin
					restart = 1'b1;
				end
			endcase
		end

		if (restart) begin
			phase_d       = tkfr_pkg::PH_IDLE;
			running_sum_d = 8'd0;
			byte_index_d  = 8'd0;
			addressed_d   = 1'b1;
			checksum_ok_d = 1'b1;
			timer_on_d    = 1'b0;
			idle_count_d  = 16'd0;
		end

		// A start token while idle opens a frame and starts the timer.
		if (op == tkfr_pkg::OP_BYTE && phase_q == tkfr_pkg::PH_IDLE &&
			rx_byte == tkfr_pkg::START_TOKEN) begin
			timer_on_d = 1'b1;
			phase_d    = tkfr_pkg::PH_LENGTH;
		end

		res.kind    = kind;
		res.command = command_byte_d;
		res.length  = frame_length_d;
	end

	// Parser state registers, updated once per processed item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= tkfr_pkg::PH_IDLE;
			frame_length_q <= 8'd0;
			running_sum_q  <= 8'd0;
			byte_index_q   <= 8'd0;
			command_byte_q <= 8'd0;
			addressed_q    <= 1'b1;
			checksum_ok_q  <= 1'b1;
			idle_count_q   <= 16'd0;
			timer_on_q     <= 1'b0;
		end else if (step) begin
			phase_q        <= phase_d;
			frame_length_q <= frame_length_d;
			running_sum_q  <= running_sum_d;
			byte_index_q   <= byte_index_d;
			command_byte_q <= command_byte_d;
			addressed_q    <= addressed_d;
			checksum_ok_q  <= checksum_ok_d;
			idle_count_q   <= idle_count_d;
			timer_on_q     <= timer_on_d;
		end
	end

	// A frame in progress always has the inactivity timer running.
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != tkfr_pkg::PH_IDLE |-> timer_on_q)
		else $error("frame in progress with timer stopped");

	// While in the payload the index stays below the frame length.
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == tkfr_pkg::PH_PAYLOAD |-> byte_index_q < frame_length_q)
		else $error("payload index ran past frame length");

	// Payload results come only from the payload phase of an addressed frame.
	assert property (@(posedge clk) disable iff (!arst_n)
		step && res_valid && res.kind == tkfr_pkg::KIND_PAYLOAD
		|-> phase_q == tkfr_pkg::PH_PAYLOAD && addressed_q)
		else $error("payload result outside an addressed payload");

endmodule

// ===== hw/rtl/tkfr_out_reg.sv =====
// Result register of the token framed packet receiver: holds one result
// until the receiver takes it. Depends on tkfr_pkg.
`timescale 1ns / 1ps

module tkfr_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  tkfr_pkg::result_t load_data,
	input  logic              out_stall,
	output logic              free,
	output logic              out_valid,
	output tkfr_pkg::result_t out_data
);

	logic              valid_q;
	tkfr_pkg::result_t data_q;

	// The register can take a new result when empty or being drained now.
	assign free      = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	// Valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (free && load) begin
			data_q <= load_data;
		end
	end

endmodule

// ===== hw/rtl/token_framed_packet_receiver.sv =====
// Top level of the token framed packet receiver.
// Depends on tkfr_pkg, tkfr_deframer and tkfr_out_reg.
`timescale 1ns / 1ps

// Usage:
// The input channel (in_valid, in_stall, op, rx_byte) carries one request per
// received byte (op 0) or per timer tick (op 1). The output channel (out_valid,
// out_stall, kind and the frame fields) carries payload bytes of frames for
// this node, each with its index, and one verdict per addressed frame:
// accepted, bad checksum, bad end token or timeout.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) sets
// the node address (index 0) and the timeout in ticks (index 1); write it only
// while no request is in flight. It is always ready.
// A request is captured in the input register and parsed from there; its result
// is loaded into the result register and presented from it. One request can be
// accepted every cycle while in_stall is low; the per-byte parser update is one
// pass of combinational logic.
// When the receiver stalls, the held result stays on the outputs and one more
// request may wait in the input register; further requests are stalled.
// Requests that give no result pass even while a result is held.
// Reset clears the parser to idle with the timer stopped, empties both
// registers and sets the node address to 0 and the timeout to 25000 ticks.

module token_framed_packet_receiver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [7:0]  payload_byte,
	output logic [7:0]  payload_index,
	output logic [7:0]  command,
	output logic [7:0]  length,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	logic        valid_s1;
	logic        op_s1;
	logic [7:0]  byte_s1;
	logic [7:0]  node_address_q;
	logic [15:0] timeout_ticks_q;
	logic        step;
	logic        res_valid;
	logic        out_free;
	tkfr_pkg::result_t res;
	tkfr_pkg::result_t out_data;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_address_q  <= tkfr_pkg::NODE_ADDRESS_RST;
			timeout_ticks_q <= tkfr_pkg::TIMEOUT_TICKS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tkfr_pkg::CFG_NODE_ADDRESS:  node_address_q  <= cfg_data[7:0];
				tkfr_pkg::CFG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The held request advances when its result, if any, has room.
	assign step     = valid_s1 && (out_free || !res_valid);
	assign in_stall = valid_s1 && !step;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1   <= op;
			byte_s1 <= rx_byte;
		end
	end

	tkfr_deframer u_deframer (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.op            (op_s1),
		.rx_byte       (byte_s1),
		.node_address  (node_address_q),
		.timeout_ticks (timeout_ticks_q),
		.res_valid     (res_valid),
		.res           (res)
	);

	tkfr_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step && res_valid),
		.load_data (res),
		.out_stall (out_stall),
		.free      (out_free),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

	// Result fields to ports.
	assign kind          = out_data.kind;
	assign payload_byte  = out_data.payload_byte;
	assign payload_index = out_data.payload_index;
	assign command       = out_data.command;
	assign length        = out_data.length;

endmodule

// ===== bench/tkfr_checker.sv =====
// Checker for the token framed packet receiver: watches the request, result and register
// channels, predicts every result of the deframer and compares it with the block's output.
// Depends on tkfr_pkg.
`timescale 1ns / 1ps

module tkfr_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        op,
	input  logic [7:0]  rx_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  kind,
	input  logic [7:0]  payload_byte,
	input  logic [7:0]  payload_index,
	input  logic [7:0]  command,
	input  logic [7:0]  length,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          n_expected
);

	// Register copies.
	logic [7:0]  my_addr;
	logic [15:0] tick_limit;

	// Deframer state copies.
	tkfr_pkg::phase_t rx_phase;
	logic [7:0]  frm_len;
	logic [7:0]  sum_acc;
	logic [7:0]  pay_idx;
	logic [7:0]  cmd_latch;
	logic        for_us;
	logic [15:0] quiet_ticks;
	logic        timer_run;
	logic        sum_good;

	// Results still owed by the block, oldest first.
	tkfr_pkg::result_t owed_results[$];

	// Drop the frame in progress and wait for a new start token.
	function automatic void restart_frame();
		rx_phase    = tkfr_pkg::PH_IDLE;
		sum_acc     = 8'd0;
		pay_idx     = 8'd0;
		for_us      = 1'b1;
		sum_good    = 1'b1;
		timer_run   = 1'b0;
		quiet_ticks = 16'd0;
	endfunction

	function automatic tkfr_pkg::result_t make_result(tkfr_pkg::kind_t k, logic [7:0] pb,
			logic [7:0] pi);
		tkfr_pkg::result_t r;
		r.kind          = k;
		r.payload_byte  = pb;
		r.payload_index = pi;
		r.command       = cmd_latch;
		r.length        = frm_len;
		return r;
	endfunction

	// Advance the deframer by one byte or tick and tell whether a result comes out.
	task automatic step_deframer(input logic is_tick, input logic [7:0] b,
			output bit emit, output tkfr_pkg::result_t r);
		logic [16:0] nxt;
		logic [7:0]  idx;
		bit          rep;
		bit          ck;
		emit = 1'b0;
		r    = '0;
		if (is_tick == tkfr_pkg::OP_TICK) begin
			if (timer_run) begin
				nxt = {1'b0, quiet_ticks} + 17'd1;
				if (nxt >= {1'b0, tick_limit}) begin
					// Only frames known to be ours and past the address report a timeout.
					rep = for_us && rx_phase >= tkfr_pkg::PH_COMMAND &&
						rx_phase <= tkfr_pkg::PH_ENDTOK;
					restart_frame();
					if (rep) begin
						emit = 1'b1;
						r    = make_result(tkfr_pkg::KIND_TIMEOUT, 8'd0, 8'd0);
					end
				end else begin
					quiet_ticks = nxt[15:0];
				end
			end
		end else begin
			case (rx_phase)
				tkfr_pkg::PH_IDLE: begin
					restart_frame();
					if (b == tkfr_pkg::START_TOKEN) begin
						timer_run = 1'b1;
						rx_phase  = tkfr_pkg::PH_LENGTH;
					end
				end
				tkfr_pkg::PH_LENGTH: begin
					quiet_ticks = 16'd0;
					frm_len     = b;
					sum_acc     = sum_acc + b;
					rx_phase    = tkfr_pkg::PH_ADDRESS;
				end
				tkfr_pkg::PH_ADDRESS: begin
					quiet_ticks = 16'd0;
					if (b == my_addr)
						sum_acc = sum_acc + b;
					else
						for_us = 1'b0;
					rx_phase = tkfr_pkg::PH_COMMAND;
				end
				tkfr_pkg::PH_COMMAND: begin
					quiet_ticks = 16'd0;
					if (for_us) begin
						cmd_latch = b;
						sum_acc   = sum_acc + b;
					end
					rx_phase = (frm_len != 8'd0) ? tkfr_pkg::PH_PAYLOAD : tkfr_pkg::PH_CKSUM;
				end
				tkfr_pkg::PH_PAYLOAD: begin
					idx         = pay_idx;
					quiet_ticks = 16'd0;
					pay_idx     = pay_idx + 8'd1;
					if (pay_idx >= frm_len)
						rx_phase = tkfr_pkg::PH_CKSUM;
					if (for_us) begin
						sum_acc = sum_acc + b;
						emit    = 1'b1;
						r       = make_result(tkfr_pkg::KIND_PAYLOAD, b, idx);
					end
				end
				tkfr_pkg::PH_CKSUM: begin
					quiet_ticks = 16'd0;
					if (b != ~sum_acc)
						sum_good = 1'b0;
					rx_phase = tkfr_pkg::PH_ENDTOK;
				end
				tkfr_pkg::PH_ENDTOK: begin
					// A bad checksum outranks a bad end token.
					rep = for_us;
					ck  = sum_good;
					restart_frame();
					if (rep) begin
						emit = 1'b1;
						if (!ck)
							r = make_result(tkfr_pkg::KIND_BAD_SUM, 8'd0, 8'd0);
						else if (b != tkfr_pkg::END_TOKEN)
							r = make_result(tkfr_pkg::KIND_BAD_END, 8'd0, 8'd0);
						else
							r = make_result(tkfr_pkg::KIND_ACCEPTED, 8'd0, 8'd0);
					end
				end
				default: begin
					restart_frame();
				end
			endcase
		end
	endtask

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// Compare results first: a result never stems from a request of the same edge.
	always @(posedge clk or negedge arst_n) begin
		tkfr_pkg::result_t want;
		tkfr_pkg::result_t got;
		bit      emit;
		if (!arst_n) begin
			my_addr    = tkfr_pkg::NODE_ADDRESS_RST;
			tick_limit = tkfr_pkg::TIMEOUT_TICKS_RST;
			frm_len    = 8'd0;
			cmd_latch  = 8'd0;
			restart_frame();
			owed_results.delete();
			fail_count = 0;
			n_expected <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (owed_results.size() == 0) begin
					$error("result with no request behind it: kind %0d", kind);
					fail_count++;
				end else begin
					want = owed_results.pop_front();
					check_field("kind", 8'(want.kind), 8'(kind));
					check_field("payload_byte", want.payload_byte, payload_byte);
					check_field("payload_index", want.payload_index, payload_index);
					check_field("command", want.command, command);
					check_field("length", want.length, length);
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == tkfr_pkg::CFG_NODE_ADDRESS)
					my_addr = cfg_data[7:0];
				else
					tick_limit = cfg_data;
			end
			if (in_valid && !in_stall) begin
				step_deframer(op, rx_byte, emit, got);
				if (emit)
					owed_results.push_back(got);
			end
			n_expected <= owed_results.size();
		end
	end

endmodule

// ===== bench/tb_token_framed_packet_receiver.sv =====
// Testbench top for the token framed packet receiver: drives framed byte and tick requests
// with random gaps and result stalls, and gives the verdict from the checker's failure count.
// Depends on tkfr_pkg, token_framed_packet_receiver and tkfr_checker.
`timescale 1ns / 1ps

module tb_token_framed_packet_receiver;

	localparam int DRAIN_CYCLES = 4;
	localparam int STUCK_LIMIT  = 5000;
	localparam int PHASE_ITEMS  = 230;

	// Ways of breaking a frame.
	localparam int FL_NONE = 0;
	localparam int FL_SUM  = 1;
	localparam int FL_END  = 2;
	localparam int FL_BOTH = 3;
	localparam int FL_CUT  = 4;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic        op        = tkfr_pkg::OP_BYTE;
	logic [7:0]  rx_byte   = 8'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  kind;
	logic [7:0]  payload_byte;
	logic [7:0]  payload_index;
	logic [7:0]  command;
	logic [7:0]  length;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = tkfr_pkg::CFG_NODE_ADDRESS;
	logic [15:0] cfg_data  = 16'd0;

	int          fail_count;
	int          n_expected;
	int          stuck_cycles = 0;
	int          stall_hold   = 0;
	int          frame_items  = 0;
	bit          quiet        = 1'b0;
	logic [7:0]  cur_node     = tkfr_pkg::NODE_ADDRESS_RST;
	int          cur_timeout  = int'(tkfr_pkg::TIMEOUT_TICKS_RST);

	token_framed_packet_receiver dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.op            (op),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.payload_byte  (payload_byte),
		.payload_index (payload_index),
		.command       (command),
		.length        (length),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	tkfr_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.op            (op),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.payload_byte  (payload_byte),
		.payload_index (payload_index),
		.command       (command),
		.length        (length),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.n_expected    (n_expected)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Gap length in cycles: mostly none or short, now and then long.
	function automatic int idle_len();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Result side: stall in runs of random length.
	always @(posedge clk) begin
		if (stall_hold != 0) begin
			stall_hold <= stall_hold - 1;
		end else begin
			out_stall  <= !quiet && ($urandom_range(0, 2) == 0);
			stall_hold <= idle_len();
		end
	end

	// Watchdog on cycles in which no channel moves anything.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready)) begin
				stuck_cycles <= 0;
			end else if (stuck_cycles + 1 >= STUCK_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end else begin
				stuck_cycles <= stuck_cycles + 1;
			end
		end
	end

	// Offer one request and hold it until it is taken.
	task automatic send_req(input logic o, input logic [7:0] b);
		int gap;
		gap = idle_len();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op       <= o;
		rx_byte  <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_ticks(input int n);
		repeat (n) send_req(tkfr_pkg::OP_TICK, 8'($urandom));
	endtask

	// Wait until every owed result is out and the pipeline has emptied.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (n_expected != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write both registers back to back; the block must be idle.
	task automatic configure(input logic [7:0] node, input int ticks);
		cfg_valid <= 1'b1;
		cfg_index <= tkfr_pkg::CFG_NODE_ADDRESS;
		cfg_data  <= {8'($urandom), node};
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= tkfr_pkg::CFG_TIMEOUT_TICKS;
		cfg_data  <= 16'(ticks);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid   <= 1'b0;
		cur_node    = node;
		cur_timeout = ticks;
	endtask

	// Send one frame with random payload, possibly broken, with ticks between bytes.
	task automatic send_frame(input logic [7:0] addr, input logic [7:0] cmd,
			input logic [7:0] len, input int flaw);
		logic [7:0] frame_bytes[$];
		logic [7:0] sum;
		logic [7:0] p;
		int         cut;
		int         gapmax;
		int         n;
		frame_bytes = {tkfr_pkg::START_TOKEN, len, addr, cmd};
		sum = len + addr + cmd;
		for (int i = 0; i < int'(len); i++) begin
			p = 8'($urandom);
			frame_bytes.push_back(p);
			sum = sum + p;
		end
		p = ~sum;
		if (flaw == FL_SUM || flaw == FL_BOTH)
			p = p ^ 8'($urandom_range(1, 255));
		frame_bytes.push_back(p);
		p = tkfr_pkg::END_TOKEN;
		if (flaw == FL_END || flaw == FL_BOTH)
			p = p ^ 8'($urandom_range(1, 255));
		frame_bytes.push_back(p);
		n = frame_bytes.size();
		cut = (flaw == FL_CUT) ? $urandom_range(1, n - 1) : n;
		// Ticks between bytes stay below the timeout, except when it is one or zero.
		gapmax = (cur_timeout > 1) ? ((cur_timeout - 1 < 30) ? cur_timeout - 1 : 30) : 1;
		for (int k = 0; k < cut; k++) begin
			if (k != 0 && $urandom_range(0, 9) == 0) begin
				n = $urandom_range(1, gapmax);
				send_ticks(n);
				frame_items += n;
			end
			send_req(tkfr_pkg::OP_BYTE, frame_bytes[k]);
			frame_items++;
		end
		if (flaw == FL_CUT) begin
			n = (cur_timeout == 0) ? 1 : cur_timeout;
			send_ticks(n);
			frame_items += n;
		end
	endtask

	// One random stretch of traffic: mostly frames, some noise and idle ticks.
	task automatic random_traffic();
		int         r;
		int         flaw;
		logic [7:0] addr;
		logic [7:0] len;
		logic [7:0] b;
		if ($urandom_range(0, 19) == 0)
			quiet = !quiet;
		r = $urandom_range(0, 99);
		if (r >= 94) begin
			send_ticks($urandom_range(1, 5));
		end else if (r >= 86) begin
			repeat ($urandom_range(1, 4)) begin
				b = 8'($urandom);
				if (b == tkfr_pkg::START_TOKEN)
					b = 8'h00;
				send_req(tkfr_pkg::OP_BYTE, b);
			end
		end else begin
			if (r < 60)
				flaw = FL_NONE;
			else if (r < 68)
				flaw = FL_SUM;
			else if (r < 74)
				flaw = FL_END;
			else if (r < 78)
				flaw = FL_BOTH;
			else
				flaw = FL_CUT;
			// Running into a long timeout costs too many ticks.
			if (flaw == FL_CUT && cur_timeout > 64)
				flaw = FL_SUM;
			addr = ($urandom_range(0, 9) < 7) ? cur_node : 8'($urandom);
			r = $urandom_range(0, 99);
			if (r < 85)
				len = 8'($urandom_range(0, 8));
			else if (r < 98)
				len = 8'($urandom_range(9, 40));
			else
				len = 8'($urandom_range(41, 255));
			send_frame(addr, 8'($urandom), len, flaw);
		end
	endtask

	initial begin
		int         target;
		logic [7:0] node_set[7];
		int         to_set[7];
		node_set = '{8'h00, 8'hFF, 8'($urandom), 8'h5A, 8'($urandom), 8'($urandom),
			8'($urandom)};
		to_set = '{1, 65535, $urandom_range(2, 20), 0, 25000, $urandom_range(2, 6),
			$urandom_range(21, 64)};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values: idle ticks and noise are dropped, node 0 is answered.
		send_ticks(2);
		send_req(tkfr_pkg::OP_BYTE, tkfr_pkg::END_TOKEN);
		send_req(tkfr_pkg::OP_BYTE, 8'h00);
		send_frame(8'h00, 8'hFF, 8'd0, FL_NONE);
		settle();

		// Highest address, short timeout, each kind of verdict.
		configure(8'hFF, 3);
		send_frame(8'hFF, 8'h00, 8'd2, FL_NONE);
		send_frame(8'hFF, 8'h7E, 8'd0, FL_BOTH);
		send_frame(8'hFF, 8'h81, 8'd1, FL_END);
		// A frame stopping after its command byte times out.
		send_req(tkfr_pkg::OP_BYTE, tkfr_pkg::START_TOKEN);
		send_req(tkfr_pkg::OP_BYTE, 8'd2);
		send_req(tkfr_pkg::OP_BYTE, 8'hFF);
		send_req(tkfr_pkg::OP_BYTE, 8'h33);
		send_ticks(3);

		// Random phases over several register settings.
		target = 0;
		for (int ph = 0; ph < 7; ph++) begin
			settle();
			configure(node_set[ph], to_set[ph]);
			if (ph == 0)
				send_frame(cur_node, 8'($urandom), 8'd255, FL_NONE);
			target += PHASE_ITEMS;
			while (frame_items < target) random_traffic();
		end

		// Timeout boundary: one tick short is survived, the full count is not.
		settle();
		quiet = 1'b1;
		configure(8'($urandom), 9);
		send_req(tkfr_pkg::OP_BYTE, tkfr_pkg::START_TOKEN);
		send_req(tkfr_pkg::OP_BYTE, 8'd3);
		send_req(tkfr_pkg::OP_BYTE, cur_node);
		send_req(tkfr_pkg::OP_BYTE, 8'hA5);
		send_req(tkfr_pkg::OP_BYTE, 8'h10);
		send_ticks(8);
		send_req(tkfr_pkg::OP_BYTE, 8'h20);
		send_ticks(9);
		settle();

		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
